// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL in this folder.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("assertion failed: condition does not hold");

// Check that a trigger implies a condition at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
    else $error("assertion failed: condition after trigger does not hold");

// Check that a trigger implies a condition at the same clock edge.
`define ASSERT_IMPLY(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
    else $error("assertion failed: implication does not hold");

`endif

// ----- rtl/core/mbrsp_pkg.sv -----
// Types and constants for the Modbus response PDU parser.
// No dependencies; used by modbus_response_pdu_parser_core.
`timescale 1ns / 1ps

package mbrsp_pkg;

  // Limits on the declared byte count
  localparam logic [6:0] MAX_REGISTER_WORDS = 7'd125;
  localparam logic [7:0] MAX_BIT_BYTES      = 8'd250;

  // Protocol constants
  localparam logic [7:0] EXC_FLAG       = 8'h80;
  localparam logic [9:0] WRITE_ECHO_LEN = 10'd5;
  localparam logic [8:0] POS_MAX        = 9'd511;

  // Result queue depth
  localparam int unsigned FIFO_DEPTH = 4;

  // Configuration register indexes
  localparam logic [0:0] CFG_EXPECTED_FUNCTION = 1'b0;
  localparam logic [0:0] CFG_RESPONSE_KIND     = 1'b1;

  // Response kinds (code 3 acts as write echo)
  localparam logic [1:0] RESP_REGISTERS = 2'd0;
  localparam logic [1:0] RESP_BITS      = 2'd1;
  localparam logic [1:0] RESP_WRITE     = 2'd2;

  typedef enum logic [1:0] {
    KIND_REG_WORD = 2'd0,
    KIND_BIT_BYTE = 2'd1,
    KIND_STATUS   = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_TOO_SHORT      = 3'd1,
    ST_EXCEPTION      = 3'd2,
    ST_FUNC_MISMATCH  = 3'd3,
    ST_COUNT_MISMATCH = 3'd4
  } status_t;

  typedef struct packed {
    result_kind_t kind;
    logic [15:0]  value;
    status_t      status;
    logic [7:0]   exc_code;
    logic         end_of_pdu;
  } result_t;

endpackage

// ----- rtl/core/modbus_response_pdu_parser_core.sv -----
// Streaming Modbus response PDU parser, top level.
// Depends on mbrsp_pkg and assert_macros.svh.
// The parser takes one PDU byte per cycle while in_ready is high and decides on it in a
// single pass between its state registers and a four-entry result queue; results leave
// one per cycle while out_ready is high. A byte that closes a PDU and also completes a
// register word or bit byte makes two results, so it needs two queue slots: in_ready
// drops while fewer than two queue slots are free. With a consumer that never stalls
// the queue holds at most two results, so bytes flow at one per cycle without a gap.
// Data results are provisional until the closing status result reads ok.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module modbus_response_pdu_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  // request input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_input,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_value,
  output logic [2:0]  out_status,
  output logic [7:0]  out_exc_code,
  output logic        out_end_of_pdu,
  // configuration
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int unsigned PTR_W = $clog2(mbrsp_pkg::FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(mbrsp_pkg::FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] READY_MAX = CNT_W'(mbrsp_pkg::FIFO_DEPTH - 2);

  // configuration and parse state
  logic [7:0] expected_function_r;
  logic [1:0] response_kind_r;
  logic [8:0] byte_position_r, byte_position_nxt;
  logic [7:0] function_byte_r, function_byte_nxt;
  logic [7:0] declared_count_r, declared_count_nxt;
  logic [7:0] held_high_byte_r, held_high_byte_nxt;

  // result queue
  mbrsp_pkg::result_t queue_r [mbrsp_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic in_fire, out_fire;
  logic [7:0] fn_cur, cnt_cur, exc_fn;
  logic [8:0] data_idx;
  logic [9:0] pdu_len, need_len;
  logic fc_ok, data_vld, reg_cnt_ok, bit_cnt_ok;
  mbrsp_pkg::status_t st;
  mbrsp_pkg::result_t data_res, stat_res, first_res;
  logic [1:0] n_push;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (count_r <= READY_MAX);

  // decode the incoming byte against the held state
  always_comb begin
    fn_cur     = (byte_position_r == 9'd0) ? in_data_byte : function_byte_r;
    cnt_cur    = (byte_position_r == 9'd1) ? in_data_byte : declared_count_r;
    exc_fn     = expected_function_r | mbrsp_pkg::EXC_FLAG;
    data_idx   = byte_position_r - 9'd2;
    fc_ok      = (function_byte_r == expected_function_r) && (function_byte_r != exc_fn);
    reg_cnt_ok = !declared_count_r[0] &&
                 (declared_count_r[7:1] <= mbrsp_pkg::MAX_REGISTER_WORDS);
    bit_cnt_ok = (declared_count_r <= mbrsp_pkg::MAX_BIT_BYTES);
    pdu_len    = {1'b0, byte_position_r} + 10'd1;
    need_len   = 10'd2 + {2'b00, cnt_cur};

    held_high_byte_nxt = held_high_byte_r;
    data_vld           = 1'b0;
    data_res           = '0;

    // emit data only while the header is sound and the byte is inside the count
    if (byte_position_r >= 9'd2 && fc_ok && data_idx < {1'b0, declared_count_r}) begin
      unique case (response_kind_r)
        mbrsp_pkg::RESP_REGISTERS: begin
          if (reg_cnt_ok) begin
            if (!data_idx[0]) begin
              held_high_byte_nxt = in_data_byte;
            end else begin
              data_vld       = 1'b1;
              data_res.kind  = mbrsp_pkg::KIND_REG_WORD;
              data_res.value = {held_high_byte_r, in_data_byte};
            end
          end
        end
        mbrsp_pkg::RESP_BITS: begin
          if (bit_cnt_ok) begin
            data_vld       = 1'b1;
            data_res.kind  = mbrsp_pkg::KIND_BIT_BYTE;
            data_res.value = {8'h00, in_data_byte};
          end
        end
        default: begin
          data_vld = 1'b0;
        end
      endcase
    end

    // closing status in check order
    if (pdu_len < 10'd2) begin
      st = mbrsp_pkg::ST_TOO_SHORT;
    end else if (fn_cur == exc_fn) begin
      st = mbrsp_pkg::ST_EXCEPTION;
    end else if (fn_cur != expected_function_r) begin
      st = mbrsp_pkg::ST_FUNC_MISMATCH;
    end else if (response_kind_r == mbrsp_pkg::RESP_REGISTERS) begin
      if (cnt_cur[0]) begin
        st = mbrsp_pkg::ST_COUNT_MISMATCH;
      end else if (pdu_len < need_len) begin
        st = mbrsp_pkg::ST_TOO_SHORT;
      end else if (cnt_cur[7:1] > mbrsp_pkg::MAX_REGISTER_WORDS) begin
        st = mbrsp_pkg::ST_COUNT_MISMATCH;
      end else begin
        st = mbrsp_pkg::ST_OK;
      end
    end else if (response_kind_r == mbrsp_pkg::RESP_BITS) begin
      if (pdu_len < need_len) begin
        st = mbrsp_pkg::ST_TOO_SHORT;
      end else if (cnt_cur > mbrsp_pkg::MAX_BIT_BYTES) begin
        st = mbrsp_pkg::ST_COUNT_MISMATCH;
      end else begin
        st = mbrsp_pkg::ST_OK;
      end
    end else begin
      st = (pdu_len != mbrsp_pkg::WRITE_ECHO_LEN) ? mbrsp_pkg::ST_TOO_SHORT
                                                  : mbrsp_pkg::ST_OK;
    end

    stat_res            = '0;
    stat_res.kind       = mbrsp_pkg::KIND_STATUS;
    stat_res.status     = st;
    stat_res.exc_code   = (st == mbrsp_pkg::ST_EXCEPTION) ? cnt_cur : 8'h00;
    stat_res.end_of_pdu = 1'b1;

    first_res = data_vld ? data_res : stat_res;
    n_push    = in_fire ? ({1'b0, data_vld} + {1'b0, in_end_of_input}) : 2'd0;

    // advance the header state, clear it after the final byte
    function_byte_nxt  = (byte_position_r == 9'd0) ? in_data_byte : function_byte_r;
    declared_count_nxt = (byte_position_r == 9'd1) ? in_data_byte : declared_count_r;
    if (in_end_of_input) begin
      byte_position_nxt  = 9'd0;
      function_byte_nxt  = 8'h00;
      declared_count_nxt = 8'h00;
      held_high_byte_nxt = 8'h00;
    end else if (byte_position_r != mbrsp_pkg::POS_MAX) begin
      byte_position_nxt = byte_position_r + 9'd1;
    end else begin
      byte_position_nxt = byte_position_r;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_function_r <= 8'd3;
      response_kind_r     <= mbrsp_pkg::RESP_REGISTERS;
    end else if (cfg_we) begin
      if (cfg_index == mbrsp_pkg::CFG_EXPECTED_FUNCTION) begin
        expected_function_r <= cfg_wdata;
      end else begin
        response_kind_r <= cfg_wdata[1:0];
      end
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r  <= 9'd0;
      function_byte_r  <= 8'h00;
      declared_count_r <= 8'h00;
      held_high_byte_r <= 8'h00;
    end else if (in_fire) begin
      byte_position_r  <= byte_position_nxt;
      function_byte_r  <= function_byte_nxt;
      declared_count_r <= declared_count_nxt;
      held_high_byte_r <= held_high_byte_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue_r[wr_ptr_r] <= first_res;
    end
    if (n_push == 2'd2) begin
      queue_r[wr_ptr_r + PTR_W'(1)] <= stat_res;
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(n_push);
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(n_push) - CNT_W'(out_fire);
    end
  end

  // drive the result port from the queue head
  assign out_valid       = (count_r != '0);
  assign out_result_kind = queue_r[rd_ptr_r].kind;
  assign out_value       = queue_r[rd_ptr_r].value;
  assign out_status      = queue_r[rd_ptr_r].status;
  assign out_exc_code    = queue_r[rd_ptr_r].exc_code;
  assign out_end_of_pdu  = queue_r[rd_ptr_r].end_of_pdu;

  // checks
  `ASSERT_ALWAYS(a_queue_bound, clk, rst_n, count_r <= CNT_W'(mbrsp_pkg::FIFO_DEPTH))
  `ASSERT_NEXT(a_pdu_restart, clk, rst_n, in_fire && in_end_of_input, byte_position_r == 9'd0)
  `ASSERT_IMPLY(a_status_closes, clk, rst_n, out_valid && out_end_of_pdu, out_result_kind == mbrsp_pkg::KIND_STATUS)

endmodule

// ----- bench/modbus_response_pdu_parser_checker.sv -----
// Result checker for the Modbus response PDU parser: follows the request,
// result and configuration ports, predicts each result and compares in order.
// Depends on mbrsp_pkg; instantiated by modbus_response_pdu_parser_core_test.
`timescale 1ns / 1ps

module modbus_response_pdu_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_input,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_result_kind,
  input  logic [15:0] out_value,
  input  logic [2:0]  out_status,
  input  logic [7:0]  out_exc_code,
  input  logic        out_end_of_pdu,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int unsigned mismatch_count,
  output int unsigned outstanding
);
  import mbrsp_pkg::*;

  localparam int unsigned REPORT_CAP = 200;

  // Shadow configuration and parse state
  logic [7:0] exp_func;
  logic [1:0] resp_kind;
  logic [8:0] byte_pos;
  logic [7:0] func_byte;
  logic [7:0] count_byte;
  logic [7:0] high_byte;

  result_t     awaited_results[$];
  int unsigned report_lines;

  // Status of a PDU that closes at the given length
  function automatic status_t closing_status(input logic [9:0] pdu_len);
    logic [9:0] needed;
    needed = 10'd2 + {2'b00, count_byte};
    if (pdu_len < 10'd2) return ST_TOO_SHORT;
    if (func_byte == (exp_func | EXC_FLAG)) return ST_EXCEPTION;
    if (func_byte != exp_func) return ST_FUNC_MISMATCH;
    if (resp_kind == RESP_REGISTERS) begin
      if (count_byte[0]) return ST_COUNT_MISMATCH;
      if (pdu_len < needed) return ST_TOO_SHORT;
      if (count_byte[7:1] > MAX_REGISTER_WORDS) return ST_COUNT_MISMATCH;
      return ST_OK;
    end
    if (resp_kind == RESP_BITS) begin
      if (pdu_len < needed) return ST_TOO_SHORT;
      if (count_byte > MAX_BIT_BYTES) return ST_COUNT_MISMATCH;
      return ST_OK;
    end
    // any other kind checks the write echo length
    if (pdu_len != WRITE_ECHO_LEN) return ST_TOO_SHORT;
    return ST_OK;
  endfunction

  // Advance the parse state by one request byte and queue what it yields
  task automatic parse_response_byte(input logic [7:0] b, input logic last);
    logic [8:0] pos;
    logic [8:0] offset;
    logic       func_ok;
    status_t    st;
    result_t    r;
    pos = byte_pos;
    if (pos == 9'd0) begin
      func_byte = b;
    end else if (pos == 9'd1) begin
      count_byte = b;
    end else begin
      offset  = pos - 9'd2;
      func_ok = (func_byte == exp_func) && (func_byte != (exp_func | EXC_FLAG));
      // emit data only inside the declared count and while no error is known
      if (func_ok && offset < {1'b0, count_byte}) begin
        if (resp_kind == RESP_REGISTERS) begin
          if (!count_byte[0] && count_byte[7:1] <= MAX_REGISTER_WORDS) begin
            if (!offset[0]) begin
              high_byte = b;
            end else begin
              r.kind       = KIND_REG_WORD;
              r.value      = {high_byte, b};
              r.status     = ST_OK;
              r.exc_code   = 8'h00;
              r.end_of_pdu = 1'b0;
              awaited_results.push_back(r);
            end
          end
        end else if (resp_kind == RESP_BITS) begin
          if (count_byte <= MAX_BIT_BYTES) begin
            r.kind       = KIND_BIT_BYTE;
            r.value      = {8'h00, b};
            r.status     = ST_OK;
            r.exc_code   = 8'h00;
            r.end_of_pdu = 1'b0;
            awaited_results.push_back(r);
          end
        end
      end
    end
    // close the PDU, or advance the saturating position
    if (last) begin
      st           = closing_status({1'b0, pos} + 10'd1);
      r.kind       = KIND_STATUS;
      r.value      = 16'h0000;
      r.status     = st;
      r.exc_code   = (st == ST_EXCEPTION) ? count_byte : 8'h00;
      r.end_of_pdu = 1'b1;
      awaited_results.push_back(r);
      byte_pos   = 9'd0;
      func_byte  = 8'h00;
      count_byte = 8'h00;
      high_byte  = 8'h00;
    end else if (pos < POS_MAX) begin
      byte_pos = pos + 9'd1;
    end
  endtask

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    mismatch_count++;
    if (report_lines < REPORT_CAP) begin
      report_lines++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
    report_lines   = 0;
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      exp_func   = 8'd3;
      resp_kind  = RESP_REGISTERS;
      byte_pos   = 9'd0;
      func_byte  = 8'h00;
      count_byte = 8'h00;
      high_byte  = 8'h00;
      awaited_results.delete();
    end else begin
      // compare a delivered result with the oldest prediction
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (report_lines < REPORT_CAP) begin
            report_lines++;
            $display("%0t: result with nothing expected, got kind %0h value %0h status %0h",
                     $time, out_result_kind, out_value, out_status);
          end
        end else begin
          want = awaited_results.pop_front();
          if (want.kind !== out_result_kind)
            report_field("result_kind", 16'(want.kind), 16'(out_result_kind));
          if (want.value !== out_value)
            report_field("value", want.value, out_value);
          if (want.status !== out_status)
            report_field("status", 16'(want.status), 16'(out_status));
          if (want.exc_code !== out_exc_code)
            report_field("exc_code", 16'(want.exc_code), 16'(out_exc_code));
          if (want.end_of_pdu !== out_end_of_pdu)
            report_field("end_of_pdu", 16'(want.end_of_pdu), 16'(out_end_of_pdu));
        end
      end
      // predict from an accepted request under the configuration in force
      if (in_valid && in_ready) begin
        parse_response_byte(in_data_byte, in_end_of_input);
      end
      // track register writes, they apply from the next edge on
      if (cfg_we) begin
        case (cfg_index)
          CFG_EXPECTED_FUNCTION: exp_func = cfg_wdata;
          CFG_RESPONSE_KIND:     resp_kind = cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

// ----- bench/modbus_response_pdu_parser_core_test.sv -----
// Testbench top for modbus_response_pdu_parser_core: clock, reset, request and
// configuration stimulus, receiver back-pressure and the final verdict.
// Depends on mbrsp_pkg and modbus_response_pdu_parser_checker.
`timescale 1ns / 1ps

module modbus_response_pdu_parser_core_test;
  import mbrsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_result_kind;
  logic [15:0] out_value;
  logic [2:0]  out_status;
  logic [7:0]  out_exc_code;
  logic        out_end_of_pdu;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_EXPECTED_FUNCTION;
  logic [7:0]  cfg_wdata = 8'h00;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned cycle_count;

  int         snd_idle_pct = 16;
  int         rcv_idle_pct = 60;
  int         rcv_hold_len = 0;
  logic [7:0] pdu_bytes[$];

  modbus_response_pdu_parser_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_value       (out_value),
    .out_status      (out_status),
    .out_exc_code    (out_exc_code),
    .out_end_of_pdu  (out_end_of_pdu),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  modbus_response_pdu_parser_checker result_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_value       (out_value),
    .out_status      (out_status),
    .out_exc_code    (out_exc_code),
    .out_end_of_pdu  (out_end_of_pdu),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding)
  );

  always #4 clk = ~clk;

  // Offer one request byte; idle gaps drop valid, acceptance is sampled mid-cycle
  task automatic offer_byte(input logic [7:0] b, input logic last);
    logic taken;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_end_of_input <= last;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic offer_pdu();
    foreach (pdu_bytes[i]) offer_byte(pdu_bytes[i], i == pdu_bytes.size() - 1);
  endtask

  // Hold the sender until every predicted result has come, then settle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_parser_config(input logic [7:0] func, input logic [1:0] kind);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EXPECTED_FUNCTION;
    cfg_wdata <= func;
    @(posedge clk);
    cfg_index <= CFG_RESPONSE_KIND;
    cfg_wdata <= {6'd0, kind};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed responses with random content, plus broken ones
  task automatic build_random_pdu(input logic [7:0] func, input logic [1:0] kind);
    int pick;
    int count;
    int body;
    pdu_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      pdu_bytes.push_back(func);
      if (kind == RESP_REGISTERS || kind == RESP_BITS) begin
        if ($urandom_range(0, 39) == 0) begin
          count = $urandom_range(246, 255);
        end else begin
          count = $urandom_range(0, 12);
        end
        if (kind == RESP_REGISTERS) begin
          count = count & ~1;
          if ($urandom_range(0, 7) == 0) count = count | 1;
        end
        pdu_bytes.push_back(8'(count));
        // keep large declared counts short, the long cases are directed
        if (count > 12) begin
          body = $urandom_range(0, 4);
        end else begin
          body = count;
        end
      end else begin
        body = 4;
      end
      // bytes past the declared count
      if ($urandom_range(0, 9) == 0) body += $urandom_range(1, 3);
      repeat (body) pdu_bytes.push_back(8'($urandom()));
    end else if (pick < 78) begin
      // exception reply
      pdu_bytes.push_back(func | EXC_FLAG);
      pdu_bytes.push_back(8'($urandom()));
    end else if (pick < 86) begin
      // arbitrary function code
      repeat ($urandom_range(1, 6)) pdu_bytes.push_back(8'($urandom()));
    end else if (pick < 95) begin
      // cut short before the declared data ends
      count = $urandom_range(1, 12);
      pdu_bytes.push_back(func);
      pdu_bytes.push_back(8'(count));
      repeat ($urandom_range(0, count - 1)) pdu_bytes.push_back(8'($urandom()));
    end else begin
      pdu_bytes.push_back(($urandom_range(0, 1) == 0) ? func : 8'($urandom()));
    end
  endtask

  task automatic build_long_pdu(input logic [7:0] func, input logic [7:0] count,
                                input int len);
    pdu_bytes.delete();
    pdu_bytes.push_back(func);
    pdu_bytes.push_back(count);
    repeat (len - 2) pdu_bytes.push_back(8'($urandom()));
  endtask

  task automatic run_phase(input logic [7:0] func, input logic [1:0] kind,
                           input int byte_budget);
    int sent;
    set_parser_config(func, kind);
    sent = 0;
    while (sent < byte_budget) begin
      build_random_pdu(func, kind);
      sent += pdu_bytes.size();
      offer_pdu();
    end
  endtask

  // Receiver: random stalls, or one long counted hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rcv_hold_len != 0) begin
        out_ready <= 1'b0;
        repeat (rcv_hold_len) @(posedge clk);
        rcv_hold_len = 0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("modbus_response_pdu_parser_core: mismatch");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed responses under the reset configuration (function 3, registers)
    pdu_bytes = {8'h03};
    offer_pdu();
    pdu_bytes = {8'h03, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
    offer_pdu();
    pdu_bytes = {8'h83, 8'h05};
    offer_pdu();
    pdu_bytes = {8'h04, 8'h00};
    offer_pdu();
    pdu_bytes = {8'h03, 8'h01, 8'hAA};
    offer_pdu();
    pdu_bytes = {8'h03, 8'h04, 8'h12};
    offer_pdu();
    pdu_bytes = {8'h03, 8'h00};
    offer_pdu();
    wait_for_results();

    // Sender idles lightly, receiver heavily
    snd_idle_pct = 16;
    rcv_idle_pct = 60;
    run_phase(8'h03, RESP_REGISTERS, 20);
    wait_for_results();
    // long receiver hold-off while bit responses keep streaming in
    rcv_hold_len = 200;
    run_phase(8'h01, RESP_BITS, 20);
    // bit count above the limit in a full-length response
    build_long_pdu(8'h01, 8'd251, 253);
    offer_pdu();
    wait_for_results();
    run_phase(8'h10, RESP_WRITE, 18);
    wait_for_results();

    // Sender idles heavily, receiver lightly
    snd_idle_pct = 60;
    rcv_idle_pct = 16;
    run_phase(8'h06, 2'd3, 18);
    wait_for_results();
    run_phase(8'h00, RESP_REGISTERS, 18);
    wait_for_results();
    run_phase(8'hFF, RESP_BITS, 18);
    wait_for_results();

    // No idling on either side
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_phase(8'h80, RESP_REGISTERS, 18);
    wait_for_results();
    repeat (2) begin
      run_phase(8'($urandom()), 2'($urandom_range(0, 3)), 15);
      wait_for_results();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("modbus_response_pdu_parser_core: match");
    end else begin
      $display("modbus_response_pdu_parser_core: mismatch");
    end
    $finish;
  end

endmodule
